[rtl/core/ufdx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufdx_pkg
// Types and constants shared by the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package ufdx_pkg;

	localparam logic [7:0] START_BYTE = 8'hFF;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_LENGTH  = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_CHECK   = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		KIND_CTS       = 3'd0,
		KIND_PAYLOAD   = 3'd1,
		KIND_GOOD      = 3'd2,
		KIND_CHECK_ERR = 3'd3,
		KIND_SHORT     = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  frame_length;
		logic [2:0]  destination;
		logic [2:0]  source;
		logic        last_packet;
		logic [7:0]  function_code;
		logic        frame_last;
	} result_t;

endpackage

[rtl/core/uart_frame_deframer_xor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_deframer_xor_unit
// Deframes a byte stream of start byte, length, payload and XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (in_valid / in_ready, rx_byte) takes one received byte per
// item. The block hunts for the start byte 0xFF, reads the length byte and
// then passes each payload byte on as one result item, tagged with its index
// and the routing header. The checksum byte yields one verdict item: frame
// good, checksum error or short frame. A zero length yields a clear-to-send
// item. Start bytes, nonzero length bytes and bytes dropped while hunting give no
// result.
// Output channel (out_valid / out_ready) carries one result item per item.
// A result is registered before out_valid shows it. Throughput is one byte
// per cycle while in_ready is high, set by the phase machine and XOR accumulator.
// A result register and a one-entry skid register follow the logic, so a
// new byte is taken while a result waits; when the receiver stalls and both
// hold a result, in_ready drops until the result register drains.
// Reset puts the block into hunting with all frame state cleared and no result
// pending.
// ----------------------------------------------------------------------------
module uart_frame_deframer_xor_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] byte_index,
	output logic [7:0] frame_length,
	output logic [2:0] destination,
	output logic [2:0] source,
	output logic       last_packet,
	output logic [7:0] function_code,
	output logic       frame_last
);
	import ufdx_pkg::*;

	phase_t     phase_q;
	logic [7:0] expected_length_q;
	logic [7:0] received_count_q;
	logic [7:0] running_check_q;
	logic [7:0] route_q;
	logic [7:0] function_q;

	result_t    out_q;
	logic       out_valid_q;
	result_t    skid_q;
	logic       skid_valid_q;

	logic       accept;
	logic       take;
	logic       has_result;
	result_t    res;
	logic [7:0] route_sel;
	logic [7:0] next_count;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign take     = out_valid_q && out_ready;
	assign next_count = received_count_q + 8'd1;

	// The routing byte's own result already carries its fields.
	assign route_sel = (received_count_q == 8'd0) ? rx_byte : route_q;

	always_comb begin
		has_result = 1'b0;
		res = '0;
		unique case (phase_q)
			PH_HUNT: begin
				has_result = 1'b0;
			end
			PH_LENGTH: begin
				has_result = (rx_byte == 8'd0);
				res.kind = KIND_CTS;
				res.frame_last = 1'b1;
			end
			PH_PAYLOAD: begin
				has_result = 1'b1;
				res.kind = KIND_PAYLOAD;
				res.data_byte = rx_byte;
				res.byte_index = received_count_q;
				res.frame_length = expected_length_q;
				res.destination = route_sel[2:0];
				res.source = route_sel[5:3];
				res.last_packet = route_sel[6];
				if (received_count_q == 8'd0) begin
					res.function_code = 8'd0;
				end else if (received_count_q == 8'd1) begin
					res.function_code = rx_byte;
				end else begin
					res.function_code = function_q;
				end
			end
			PH_CHECK: begin
				has_result = 1'b1;
				if (rx_byte != running_check_q) begin
					res.kind = KIND_CHECK_ERR;
				end else if (expected_length_q == 8'd1) begin
					res.kind = KIND_SHORT;
				end else begin
					res.kind = KIND_GOOD;
				end
				res.frame_length = expected_length_q;
				res.destination = route_q[2:0];
				res.source = route_q[5:3];
				res.last_packet = route_q[6];
				// Stays zero on a one-byte frame, since the length byte clears it.
				res.function_code = function_q;
				res.frame_last = 1'b1;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			expected_length_q <= 8'd0;
			received_count_q <= 8'd0;
			running_check_q <= 8'd0;
			route_q <= 8'd0;
			function_q <= 8'd0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == START_BYTE) begin
						running_check_q <= START_BYTE;
						phase_q <= PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					expected_length_q <= rx_byte;
					if (rx_byte == 8'd0) begin
						phase_q <= PH_HUNT;
					end else begin
						running_check_q <= running_check_q ^ rx_byte;
						received_count_q <= 8'd0;
						route_q <= 8'd0;
						function_q <= 8'd0;
						phase_q <= PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					running_check_q <= running_check_q ^ rx_byte;
					if (received_count_q == 8'd0) begin
						route_q <= rx_byte;
					end else if (received_count_q == 8'd1) begin
						function_q <= rx_byte;
					end
					received_count_q <= next_count;
					if (next_count == expected_length_q) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// Result register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && has_result) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept && has_result) begin
			if (!out_valid_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign data_byte     = out_q.data_byte;
	assign byte_index    = out_q.byte_index;
	assign frame_length  = out_q.frame_length;
	assign destination   = out_q.destination;
	assign source        = out_q.source;
	assign last_packet   = out_q.last_packet;
	assign function_code = out_q.function_code;
	assign frame_last    = out_q.frame_last;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output is empty");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD || phase_q == PH_CHECK) |-> (expected_length_q != 8'd0))
		else $error("frame body phase with zero length");

	a_payload_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_PAYLOAD) |->
			(!out_q.frame_last && out_q.byte_index < out_q.frame_length))
		else $error("payload result marked as frame end or index past length");

	a_cts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_CTS) |->
			(out_q.frame_length == 8'd0 && out_q.destination == 3'd0 && out_q.frame_last))
		else $error("clear-to-send result carries frame fields");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (received_count_q < expected_length_q))
		else $error("payload count reached the announced length");

endmodule
